/* rtl/core/fixed_window_rate_limiter_core_assert.svh */
// Assertion macros for the fixed-window rate limiter core.
// Included by the modules that assert; needs no other file.
`ifndef FIXED_WINDOW_RATE_LIMITER_CORE_ASSERT_SVH
`define FIXED_WINDOW_RATE_LIMITER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// Clocked check, disabled while reset is asserted
`define FWRL_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
		else $error("fwrl assertion failed");
// Clocked check that also holds during reset
`define FWRL_ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("fwrl assertion failed");
`else
`define FWRL_ASSERT(lbl, clk, rstn, prop)
`define FWRL_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

/* rtl/core/fwrl_pkg.sv */
// Shared widths, codes and types of the fixed-window rate limiter.
// Used by the channel interfaces and the core; depends on nothing.
package fwrl_pkg;

	localparam int ID_W       = 8;
	localparam int TIME_W     = 32;
	localparam int MAXREQ_W   = 16;
	localparam int WIN_W      = 31;
	localparam int CNT_W      = 17;
	localparam int REMOVED_W  = 9;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 32;

	// Item kinds
	localparam logic REQ_CLIENT  = 1'b0;
	localparam logic REQ_CLEANUP = 1'b1;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MAX_REQUESTS = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_TICKS = 1'b1;

	// Register reset values
	localparam logic [MAXREQ_W-1:0] MAX_REQUESTS_RST = 16'd100;
	localparam logic [WIN_W-1:0]    WINDOW_TICKS_RST = 31'd1000;

	// One table entry
	typedef struct packed {
		logic              valid;
		logic [TIME_W-1:0] start;
		logic [CNT_W-1:0]  count;
	} entry_t;

endpackage

/* rtl/core/fwrl_if.sv */
// Valid/ready channel interfaces of the fixed-window rate limiter:
// request items, result items and configuration writes. Depend on fwrl_pkg.
interface fwrl_item_if;
	import fwrl_pkg::*;
	logic              valid;
	logic              ready;
	logic              req_type;
	logic [ID_W-1:0]   client_id;
	logic [TIME_W-1:0] now_time;
	modport source (output valid, output req_type, output client_id, output now_time,
		input ready);
	modport sink (input valid, input req_type, input client_id, input now_time,
		output ready);
endinterface

interface fwrl_result_if;
	import fwrl_pkg::*;
	logic                 valid;
	logic                 ready;
	logic                 limited;
	logic [REMOVED_W-1:0] evict_count;
	modport source (output valid, output limited, output evict_count, input ready);
	modport sink (input valid, input limited, input evict_count, output ready);
endinterface

interface fwrl_cfg_if;
	import fwrl_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

/* rtl/core/fixed_window_rate_limiter_core.sv */
// Fixed-window rate limiter: one table entry per client holds a valid bit, the start
// time of its current window and the request count in it, all kept in one memory
// with a registered read. A client request reads the entry, then decides and writes it back
// once the result register is free; a cleanup sweep walks the table one entry per cycle
// through the same memory port. After reset the block runs a clearing pass over every
// entry before it takes its first item; configuration writes are taken at any time.
// Client indexes wrap modulo CLIENTS. Depends on fwrl_pkg and fwrl_if.
module fixed_window_rate_limiter_core #(
	parameter int CLIENTS = 256
) (
	input  logic                  clk,
	input  logic                  arst_n,
	fwrl_item_if.sink             req,
	fwrl_result_if.source         rsp,
	fwrl_cfg_if.sink              cfg
);
	import fwrl_pkg::*;

	`include "fixed_window_rate_limiter_core_assert.svh"

	localparam int IDX_W = (CLIENTS > 1) ? $clog2(CLIENTS) : 1;
	localparam int MOD_W = 25;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CLIENTS - 1);

	typedef enum logic [4:0] {
		S_CLEAR = 5'b00001,
		S_IDLE  = 5'b00010,
		S_REQ   = 5'b00100,
		S_SWEEP = 5'b01000,
		S_FIN   = 5'b10000
	} state_t;

	state_t state_q, state_d;

	logic [MAXREQ_W-1:0]  max_req_q;
	logic [WIN_W-1:0]     window_q;
	logic [IDX_W-1:0]     sweep_q;
	logic [IDX_W-1:0]     req_idx_s1;
	logic [TIME_W-1:0]    now_s1;
	logic [REMOVED_W-1:0] removed_q;
	logic                 out_valid_q;
	logic                 limited_q;
	logic [REMOVED_W-1:0] out_removed_q;

	entry_t               mem [CLIENTS];
	entry_t               rd_q;
	logic                 rd_en;
	logic [IDX_W-1:0]     rd_addr;
	logic                 wr_en;
	logic [IDX_W-1:0]     wr_addr;
	entry_t               wr_data;

	logic [MOD_W-1:0]     id_red;
	logic [IDX_W-1:0]     id_idx;
	logic                 req_fire;
	logic                 out_free;
	logic [TIME_W-1:0]    elapsed;
	logic                 expired;
	logic [CNT_W:0]       cnt_inc;
	logic [CNT_W-1:0]     cap;
	logic [CNT_W-1:0]     cnt_next;
	logic                 req_limited;
	logic                 sweep_remove;

	assign req.ready = (state_q == S_IDLE);
	assign cfg.ready = 1'b1;
	assign req_fire  = req.valid && req.ready;
	assign out_free  = !out_valid_q || rsp.ready;

	assign rsp.valid       = out_valid_q;
	assign rsp.limited     = limited_q;
	assign rsp.evict_count = out_removed_q;

	// Wrap the client index modulo CLIENTS by restoring reduction
	always_comb begin
		id_red = MOD_W'(req.client_id);
		for (int k = 7; k >= 0; k--) begin
			if (id_red >= (MOD_W'(CLIENTS) << k)) begin
				id_red = id_red - (MOD_W'(CLIENTS) << k);
			end
		end
	end
	assign id_idx = id_red[IDX_W-1:0];

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_req_q <= MAX_REQUESTS_RST;
			window_q  <= WINDOW_TICKS_RST;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				REG_MAX_REQUESTS: max_req_q <= cfg.data[MAXREQ_W-1:0];
				REG_WINDOW_TICKS: window_q  <= cfg.data[WIN_W-1:0];
				default: ;
			endcase
		end
	end

	// Elapsed time against the entry now held in the read register
	assign elapsed = (state_q == S_REQ) ? (now_s1 - rd_q.start) : (now_s1 - rd_q.start);
	assign expired = !rd_q.valid || (elapsed > {1'b0, window_q});

	// Count update, saturating at max + 1
	assign cap         = CNT_W'(max_req_q) + CNT_W'(1);
	assign cnt_inc     = {1'b0, rd_q.count} + (CNT_W+1)'(1);
	assign cnt_next    = (cnt_inc > {1'b0, cap}) ? cap : cnt_inc[CNT_W-1:0];
	assign req_limited = !expired && (cnt_next > CNT_W'(max_req_q));

	// Sweep drops valid entries older than twice the window
	assign sweep_remove = rd_q.valid && (elapsed > {window_q, 1'b0});

	// Memory port control
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = sweep_q + IDX_W'(1);
		wr_en   = 1'b0;
		wr_addr = sweep_q;
		wr_data = '{valid: 1'b0, start: rd_q.start, count: rd_q.count};
		unique case (state_q)
			S_CLEAR: begin
				wr_en = 1'b1;
			end
			S_IDLE: begin
				rd_en   = req_fire;
				rd_addr = (req.req_type == REQ_CLEANUP) ? '0 : id_idx;
			end
			S_REQ: begin
				wr_en   = out_free;
				wr_addr = req_idx_s1;
				wr_data = expired ? entry_t'{valid: 1'b1, start: now_s1, count: CNT_W'(1)}
				                  : entry_t'{valid: 1'b1, start: rd_q.start, count: cnt_next};
			end
			S_SWEEP: begin
				rd_en = (sweep_q != LAST_IDX);
				wr_en = sweep_remove;
			end
			S_FIN: ;
			default: ;
		endcase
	end

	// Table memory with a registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	// Sequencer
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: if (sweep_q == LAST_IDX) state_d = S_IDLE;
			S_IDLE: begin
				if (req_fire) begin
					state_d = (req.req_type == REQ_CLEANUP) ? S_SWEEP : S_REQ;
				end
			end
			S_REQ:   if (out_free) state_d = S_IDLE;
			S_SWEEP: if (sweep_q == LAST_IDX) state_d = S_FIN;
			S_FIN:   if (out_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			sweep_q <= '0;
		end else begin
			state_q <= state_d;
			// Advance the entry counter through clear and sweep; rewind on every accepted item
			if (state_q == S_CLEAR || state_q == S_SWEEP) begin
				sweep_q <= (sweep_q == LAST_IDX) ? '0 : sweep_q + IDX_W'(1);
			end else if (req_fire) begin
				sweep_q <= '0;
			end
		end
	end

	// Capture the item fields and count removals
	always_ff @(posedge clk) begin
		if (req_fire) begin
			req_idx_s1 <= id_idx;
			now_s1     <= req.now_time;
			removed_q  <= '0;
		end else if (state_q == S_SWEEP && sweep_remove) begin
			removed_q <= removed_q + REMOVED_W'(1);
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == S_REQ || state_q == S_FIN) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_REQ && out_free) begin
			limited_q     <= req_limited;
			out_removed_q <= '0;
		end else if (state_q == S_FIN && out_free) begin
			limited_q     <= 1'b0;
			out_removed_q <= removed_q;
		end
	end

	`FWRL_ASSERT(a_result_source, clk, arst_n, $rose(out_valid_q) |-> $past(state_q == S_REQ || state_q == S_FIN))
	`FWRL_ASSERT(a_accept_next, clk, arst_n, req_fire |=> (state_q == S_REQ || state_q == S_SWEEP))
	`FWRL_ASSERT(a_write_window, clk, arst_n, wr_en |-> (state_q == S_CLEAR || state_q == S_REQ || state_q == S_SWEEP))
	`FWRL_ASSERT(a_result_kind, clk, arst_n, (out_valid_q && limited_q) |-> (out_removed_q == '0))
	`FWRL_ASSERT_ALWAYS(a_reset_clear, clk, !arst_n |=> !req.ready || $past(arst_n))

endmodule

/* tb/fixed_window_rate_limiter_core_tb.sv */
// Self-checking testbench for the fixed-window rate limiter core: a queue-fed driver,
// a stalling monitor and a per-client table predictor that scores every result item.
// Depends on fwrl_pkg, the fwrl channel interfaces and fixed_window_rate_limiter_core.
module fixed_window_rate_limiter_core_tb;
	import fwrl_pkg::*;

	localparam int CLIENTS         = 256;
	localparam int SWEEP_CYCLES    = CLIENTS + 2;
	localparam int HOLD_OFF_CYCLES = 400;
	localparam int RUN_LIMIT       = 2_000_000;

	typedef struct packed {
		logic              kind;
		logic [ID_W-1:0]   client;
		logic [TIME_W-1:0] stamp;
	} request_t;

	typedef struct packed {
		logic                 limited;
		logic [REMOVED_W-1:0] removed;
	} verdict_t;

	typedef enum int {RX_ALWAYS, RX_COIN, RX_SPARSE, RX_RUNS} rx_pattern_t;

	logic clk;
	logic arst_n = 1'b0;

	// Driven copies of the block inputs, known from time zero
	logic                  item_valid  = 1'b0;
	logic                  item_kind   = REQ_CLIENT;
	logic [ID_W-1:0]       item_client = '0;
	logic [TIME_W-1:0]     item_time   = '0;
	logic                  take_ready  = 1'b0;
	logic                  reg_valid   = 1'b0;
	logic [CFG_IDX_W-1:0]  reg_index   = REG_MAX_REQUESTS;
	logic [CFG_DATA_W-1:0] reg_data    = '0;

	fwrl_item_if   req_ch ();
	fwrl_result_if rsp_ch ();
	fwrl_cfg_if    cfg_ch ();

	assign req_ch.valid     = item_valid;
	assign req_ch.req_type  = item_kind;
	assign req_ch.client_id = item_client;
	assign req_ch.now_time  = item_time;
	assign rsp_ch.ready     = take_ready;
	assign cfg_ch.valid     = reg_valid;
	assign cfg_ch.index     = reg_index;
	assign cfg_ch.data      = reg_data;

	fixed_window_rate_limiter_core #(.CLIENTS(CLIENTS)) u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	// Predictor copy of the client table and the limits
	logic                tbl_valid [CLIENTS];
	logic [TIME_W-1:0]   tbl_start [CLIENTS];
	logic [CNT_W-1:0]    tbl_count [CLIENTS];
	logic [MAXREQ_W-1:0] lim_max;
	logic [WIN_W-1:0]    lim_window;

	request_t queued_requests [$];
	verdict_t pending_verdicts [$];
	request_t outgoing;
	verdict_t want;

	int queued_total   = 0;
	int answered_total = 0;
	int fault_count    = 0;
	int burst_left     = 0;
	int gap_left       = 0;
	int hold_ticket    = 0;
	int hold_served    = 0;
	int hold_left      = 0;
	int pattern_left   = 0;
	rx_pattern_t rx_pattern = RX_ALWAYS;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#(RUN_LIMIT);
		$display("fixed_window_rate_limiter_core_tb: errors");
		$finish;
	end

	// Work out the result of one item and update the table copy
	function automatic verdict_t limiter_verdict(input logic kind, input logic [ID_W-1:0] client,
		input logic [TIME_W-1:0] stamp);
		verdict_t verdict;
		logic [TIME_W-1:0] age;
		logic [CNT_W:0] next_count;
		logic [CNT_W:0] cap;
		int slot;
		verdict = '0;
		if (kind == REQ_CLIENT) begin
			slot = int'(client) % CLIENTS;
			age = stamp - tbl_start[slot];
			if (!tbl_valid[slot] || age > {1'b0, lim_window}) begin
				// open a fresh window
				tbl_valid[slot] = 1'b1;
				tbl_start[slot] = stamp;
				tbl_count[slot] = CNT_W'(1);
			end else begin
				// count up, clamped one past the limit
				cap = {2'b00, lim_max} + 1'b1;
				next_count = {1'b0, tbl_count[slot]} + 1'b1;
				if (next_count > cap)
					next_count = cap;
				tbl_count[slot] = next_count[CNT_W-1:0];
				verdict.limited = (next_count > {2'b00, lim_max});
			end
		end else begin
			// drop every entry older than two windows
			for (int i = 0; i < CLIENTS; i++) begin
				age = stamp - tbl_start[i];
				if (tbl_valid[i] && age > {lim_window, 1'b0}) begin
					tbl_valid[i] = 1'b0;
					verdict.removed = verdict.removed + 1'b1;
				end
			end
		end
		return verdict;
	endfunction

	function automatic void queue_request(input logic kind, input logic [ID_W-1:0] client,
		input logic [TIME_W-1:0] stamp);
		queued_requests.push_back('{kind, client, stamp});
		queued_total++;
	endfunction

	// Hold until every queued item has produced its result
	task automatic drain();
		while (answered_total < queued_total)
			@(posedge clk);
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] value);
		@(posedge clk);
		reg_valid <= 1'b1;
		reg_index <= idx;
		reg_data  <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		reg_valid <= 1'b0;
		if (idx == REG_MAX_REQUESTS)
			lim_max = value[MAXREQ_W-1:0];
		else
			lim_window = value[WIN_W-1:0];
	endtask

	// Write both limits; the unused upper data bits carry junk
	task automatic set_limits(input int unsigned max_req, input int unsigned win);
		write_register(REG_MAX_REQUESTS, {16'($urandom), 16'(max_req)});
		write_register(REG_WINDOW_TICKS, {1'($urandom), 31'(win)});
	endtask

	// One setting of the limits, then a stream mostly aimed at a small crowd of clients
	task automatic random_phase(input int count, input logic with_hold);
		int unsigned max_req;
		int unsigned win;
		int unsigned crowd_size;
		int roll;
		logic [ID_W-1:0] crowd [8];
		logic [TIME_W-1:0] clock_now;
		logic [TIME_W-1:0] step;
		case ($urandom_range(0, 5))
			0: max_req = 0;
			1: max_req = 1;
			2: max_req = 65535;
			3: max_req = $urandom_range(0, 65535);
			default: max_req = $urandom_range(1, 8);
		endcase
		case ($urandom_range(0, 5))
			0: win = 0;
			1: win = 1;
			2: win = 32'h7FFF_FFFF;
			3: win = $urandom & 32'h7FFF_FFFF;
			default: win = $urandom_range(1, 2000);
		endcase
		set_limits(max_req, win);
		crowd_size = $urandom_range(1, 8);
		for (int i = 0; i < 8; i++)
			crowd[i] = 8'($urandom);
		clock_now = $urandom;
		for (int n = 0; n < count; n++) begin
			roll = $urandom_range(0, 99);
			if (roll < 78) begin
				// advance time inside the window, on its edge, or just past it
				case ($urandom_range(0, 9))
					0: step = win;
					1: step = win + 1;
					default: step = $urandom_range(0, win / 4 + 1);
				endcase
				clock_now = clock_now + step;
				queue_request(REQ_CLIENT, crowd[$urandom_range(0, crowd_size - 1)], clock_now);
			end else if (roll < 88) begin
				if ($urandom_range(0, 1))
					clock_now = clock_now + 2 * win + $urandom_range(0, 2);
				queue_request(REQ_CLEANUP, 8'($urandom), clock_now);
			end else if (roll < 95) begin
				queue_request(REQ_CLIENT, 8'($urandom), $urandom);
			end else begin
				// time running backwards for a known client
				queue_request(REQ_CLIENT, crowd[$urandom_range(0, crowd_size - 1)],
					clock_now - $urandom_range(1, 50));
			end
		end
		if (with_hold)
			hold_ticket++;
		drain();
	endtask

	// Driver: offer queued items in bursts, predict each accepted one
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
			burst_left = 0;
			gap_left = 0;
		end else begin
			if (item_valid && req_ch.ready)
				pending_verdicts.push_back(limiter_verdict(item_kind, item_client, item_time));
			// move on once the current item is gone
			if (!item_valid || req_ch.ready) begin
				if (gap_left > 0) begin
					gap_left--;
					item_valid <= 1'b0;
				end else if (queued_requests.size() != 0) begin
					outgoing = queued_requests.pop_front();
					item_valid  <= 1'b1;
					item_kind   <= outgoing.kind;
					item_client <= outgoing.client;
					item_time   <= outgoing.stamp;
					if (burst_left > 1) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(1, 24);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
					end
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: score results, stall on a shifting pattern
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			take_ready <= 1'b0;
		end else begin
			if (rsp_ch.valid && take_ready) begin
				answered_total++;
				if (pending_verdicts.size() == 0) begin
					$display("%0t: unexpected result, limited %0b evicted %0d", $time,
						rsp_ch.limited, rsp_ch.evict_count);
					fault_count++;
				end else begin
					want = pending_verdicts.pop_front();
					if (rsp_ch.limited !== want.limited) begin
						$display("%0t: limited mismatch, expected %0b actual %0b", $time,
							want.limited, rsp_ch.limited);
						fault_count++;
					end
					if (rsp_ch.evict_count !== want.removed) begin
						$display("%0t: evict_count mismatch, expected %0d actual %0d", $time,
							want.removed, rsp_ch.evict_count);
						fault_count++;
					end
				end
			end
			// start a long hold-off when asked
			if (hold_served != hold_ticket) begin
				hold_served = hold_ticket;
				hold_left = HOLD_OFF_CYCLES;
			end
			if (pattern_left == 0) begin
				rx_pattern = rx_pattern_t'($urandom_range(0, 3));
				pattern_left = $urandom_range(16, 96);
			end else begin
				pattern_left--;
			end
			if (hold_left > 0) begin
				hold_left--;
				take_ready <= 1'b0;
			end else begin
				case (rx_pattern)
					RX_ALWAYS: take_ready <= 1'b1;
					RX_COIN:   take_ready <= 1'($urandom_range(0, 1));
					RX_SPARSE: take_ready <= ($urandom_range(0, 3) == 0);
					default:   take_ready <= pattern_left[2];
				endcase
			end
		end
	end

	// Stimulus: reset, directed corners, then random phases
	initial begin
		for (int i = 0; i < CLIENTS; i++) begin
			tbl_valid[i] = 1'b0;
			tbl_start[i] = '0;
			tbl_count[i] = '0;
		end
		lim_max = MAX_REQUESTS_RST;
		lim_window = WINDOW_TICKS_RST;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// reset limits: window edge, expiry, wrapped and backward time, sweeps
		queue_request(REQ_CLIENT, 8'd0, 32'd0);
		queue_request(REQ_CLIENT, 8'd255, 32'hFFFF_FFFF);
		queue_request(REQ_CLIENT, 8'd0, 32'd1000);
		queue_request(REQ_CLIENT, 8'd0, 32'd1001);
		queue_request(REQ_CLIENT, 8'd255, 32'd5);
		queue_request(REQ_CLIENT, 8'd0, 32'd500);
		queue_request(REQ_CLEANUP, 8'd0, 32'd1500);
		queue_request(REQ_CLEANUP, 8'hA5, 32'd3000);
		queue_request(REQ_CLEANUP, 8'd0, 32'd3000);
		drain();

		// zero limit and zero window
		set_limits(0, 0);
		queue_request(REQ_CLIENT, 8'd7, 32'd10);
		queue_request(REQ_CLIENT, 8'd7, 32'd10);
		queue_request(REQ_CLIENT, 8'd7, 32'd10);
		queue_request(REQ_CLIENT, 8'd7, 32'd11);
		queue_request(REQ_CLIENT, 8'd8, 32'd11);
		queue_request(REQ_CLEANUP, 8'd0, 32'd11);
		queue_request(REQ_CLEANUP, 8'd0, 32'd12);
		drain();

		// largest limit and window; build a count for the lowering case below
		set_limits(65535, 32'h7FFF_FFFF);
		repeat (6)
			queue_request(REQ_CLIENT, 8'd9, 32'd100);
		queue_request(REQ_CLIENT, 8'd200, 32'd100);
		queue_request(REQ_CLEANUP, 8'd0, 32'd98);
		drain();

		// lowered limit clamps a count already above it; then sweep both out
		set_limits(2, 1000);
		queue_request(REQ_CLIENT, 8'd9, 32'd100);
		queue_request(REQ_CLIENT, 8'd9, 32'd100);
		queue_request(REQ_CLEANUP, 8'd0, 32'd99);
		drain();

		for (int p = 0; p < 8; p++)
			random_phase(50, p == 2);

		repeat (SWEEP_CYCLES + 16) @(posedge clk);
		if (pending_verdicts.size() != 0) begin
			$display("%0t: %0d results never arrived", $time, pending_verdicts.size());
			fault_count++;
		end
		if (fault_count == 0)
			$display("fixed_window_rate_limiter_core_tb: clean");
		else
			$display("fixed_window_rate_limiter_core_tb: errors");
		$finish;
	end

endmodule
